// ===== rtl/core/dcpt_pkg.sv =====
// Shared types and constants for the dual-chamber pacing timer controller.
// No dependencies; used by every module under rtl/core.
package dcpt_pkg;

    // Timer slots, also the bit positions of the running mask
    localparam int unsigned NUM_TIMERS = 6;
    localparam int unsigned T_LRI      = 0;
    localparam int unsigned T_URI      = 1;
    localparam int unsigned T_AVI      = 2;
    localparam int unsigned T_AEI      = 3;
    localparam int unsigned T_PVARP    = 4;
    localparam int unsigned T_VRP      = 5;

    // Configuration register file
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_AV_INTERVAL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATRIAL_ESCAPE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_V_ATRIAL_REF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_V_REFRACTORY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_RATE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_RATE        = 3'd5;

    typedef logic [CFG_W-1:0]      cfg_word_t;
    typedef logic [NUM_TIMERS-1:0] tmask_t;

    // Interval reset values, ordered by timer slot
    localparam cfg_word_t RST_LRI   = 16'd950;
    localparam cfg_word_t RST_URI   = 16'd900;
    localparam cfg_word_t RST_AVI   = 16'd300;
    localparam cfg_word_t RST_AEI   = 16'd800;
    localparam cfg_word_t RST_PVARP = 16'd50;
    localparam cfg_word_t RST_VRP   = 16'd150;

    // One tick's result
    typedef struct packed {
        logic   atrial_pace;
        logic   ventricle_pace;
        tmask_t running;
    } tick_res_t;

endpackage

// ===== rtl/core/dual_chamber_pacing_timer_controller_unit.sv =====
// Top level of the dual-chamber pacing timer controller.
// Depends on dcpt_pkg, dcpt_cfg_regs and dcpt_tick_engine.

// One input beat is one timer tick carrying the sensed atrial and ventricular
// flags; each tick yields exactly one result beat with the atrial pace, the
// ventricular pace and the six running flags (bit0 LRI, bit1 URI, bit2 AVI,
// bit3 AEI, bit4 PVARP, bit5 VRP). The block sustains one tick per clock while
// m_ready is held high: a tick is first held in the input register, then the
// whole timer update (events, six parallel countdowns, expiry order) runs in one
// pass of logic into the result register that drives m_. While a result waits
// for m_ready the input register takes one more beat, then holds s_ready low
// until the result beat goes. The user writes the interval registers through
// cfg_valid/cfg_index/cfg_wdata only while the block is idle, which the block
// does not enforce; indexes past the last register are dropped. COUNT_WIDTH sets
// the counter width; intervals above its range clamp to full scale, and an
// interval of zero counts as one.
module dual_chamber_pacing_timer_controller_unit #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // tick input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_atrial_sensed,
    input  logic                            s_ventricle_sensed,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_atrial_pace,
    output logic                            m_ventricle_pace,
    output logic [5:0]                      m_running_mask,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dcpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  dcpt_pkg::cfg_word_t             cfg_wdata
);

    logic                   in_valid_reg, in_valid_next;
    logic                   in_a_reg;
    logic                   in_v_reg;
    logic                   out_valid_reg, out_valid_next;
    dcpt_pkg::tick_res_t    res_reg;
    dcpt_pkg::tick_res_t    res_next;
    logic                   advance;
    logic                   step_en;
    logic                   in_take;
    logic [COUNT_WIDTH-1:0] load_val [dcpt_pkg::NUM_TIMERS];

    // Register writes always complete in one beat
    assign cfg_ready = 1'b1;

    dcpt_cfg_regs #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .load_val (load_val)
    );

    // Result slot frees when empty or when its beat is taken this cycle
    assign advance = !out_valid_reg || m_ready;
    // Run one tick when a beat is held and the result slot can take it
    assign step_en = in_valid_reg && advance;
    // Input register accepts whenever it empties this cycle
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    dcpt_tick_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_en          (step_en),
        .atrial_sensed    (in_a_reg),
        .ventricle_sensed (in_v_reg),
        .load_val         (load_val),
        .res_next         (res_next)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step_en) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold until the next beat moves in
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_a_reg <= s_atrial_sensed;
            in_v_reg <= s_ventricle_sensed;
        end
        if (step_en) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_atrial_pace    = res_reg.atrial_pace;
    assign m_ventricle_pace = res_reg.ventricle_pace;
    assign m_running_mask   = res_reg.running;

    // An expired atrial escape interval is stopped by the end of the tick
    a_ap_clears_aei: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.atrial_pace) |-> !res_reg.running[dcpt_pkg::T_AEI])
        else $error("atrial pace reported with AEI still running");

    // A held tick that cannot advance is kept, not dropped
    a_tick_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held tick lost while result stalled");

    // Every processed tick yields a result beat
    a_step_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> out_valid_reg)
        else $error("tick processed without result beat");

    // Result slot never overwritten while its beat is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !step_en)
        else $error("pending result overwritten");

endmodule

// ===== rtl/core/dcpt_cfg_regs.sv =====
// Interval configuration registers and the count load values derived from them.
// Depends on dcpt_pkg.
module dcpt_cfg_regs #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [dcpt_pkg::CFG_IDX_W-1:0]  wr_index,
    input  dcpt_pkg::cfg_word_t             wr_data,
    output logic [COUNT_WIDTH-1:0]          load_val [dcpt_pkg::NUM_TIMERS]
);

    localparam logic [31:0] MAX_COUNT = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

    dcpt_pkg::cfg_word_t ivl_reg  [dcpt_pkg::NUM_TIMERS];
    dcpt_pkg::cfg_word_t ivl_next [dcpt_pkg::NUM_TIMERS];

    always_comb begin
        ivl_next = ivl_reg;
        if (wr_en) begin
            case (wr_index)
                dcpt_pkg::CFG_AV_INTERVAL:       ivl_next[dcpt_pkg::T_AVI]   = wr_data;
                dcpt_pkg::CFG_ATRIAL_ESCAPE:     ivl_next[dcpt_pkg::T_AEI]   = wr_data;
                dcpt_pkg::CFG_POST_V_ATRIAL_REF: ivl_next[dcpt_pkg::T_PVARP] = wr_data;
                dcpt_pkg::CFG_V_REFRACTORY:      ivl_next[dcpt_pkg::T_VRP]   = wr_data;
                dcpt_pkg::CFG_UPPER_RATE:        ivl_next[dcpt_pkg::T_URI]   = wr_data;
                dcpt_pkg::CFG_LOWER_RATE:        ivl_next[dcpt_pkg::T_LRI]   = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ivl_reg[dcpt_pkg::T_LRI]   <= dcpt_pkg::RST_LRI;
            ivl_reg[dcpt_pkg::T_URI]   <= dcpt_pkg::RST_URI;
            ivl_reg[dcpt_pkg::T_AVI]   <= dcpt_pkg::RST_AVI;
            ivl_reg[dcpt_pkg::T_AEI]   <= dcpt_pkg::RST_AEI;
            ivl_reg[dcpt_pkg::T_PVARP] <= dcpt_pkg::RST_PVARP;
            ivl_reg[dcpt_pkg::T_VRP]   <= dcpt_pkg::RST_VRP;
        end else begin
            ivl_reg <= ivl_next;
        end
    end

    // Zero loads as one; values past the counter range clamp to full scale
    always_comb begin
        logic [31:0] v32;
        for (int i = 0; i < dcpt_pkg::NUM_TIMERS; i++) begin
            v32 = 32'(ivl_reg[i]);
            if (v32 == 32'd0) begin
                load_val[i] = COUNT_WIDTH'(1);
            end else if (v32 > MAX_COUNT) begin
                load_val[i] = MAX_COUNT[COUNT_WIDTH-1:0];
            end else begin
                load_val[i] = v32[COUNT_WIDTH-1:0];
            end
        end
    end

endmodule

// ===== rtl/core/dcpt_tick_engine.sv =====
// Timer state and the single-pass tick update: events, countdowns, expiries.
// Depends on dcpt_pkg; load values come from dcpt_cfg_regs.
module dcpt_tick_engine #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step_en,
    input  logic                    atrial_sensed,
    input  logic                    ventricle_sensed,
    input  logic [COUNT_WIDTH-1:0]  load_val [dcpt_pkg::NUM_TIMERS],
    output dcpt_pkg::tick_res_t     res_next
);

    logic [COUNT_WIDTH-1:0] cnt_reg  [dcpt_pkg::NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] cnt_next [dcpt_pkg::NUM_TIMERS];
    dcpt_pkg::tmask_t       run_reg, run_next;
    logic                   ap_pend_reg, ap_pend_next;
    logic                   vp_pend_reg, vp_pend_next;

    always_comb begin
        dcpt_pkg::tmask_t fresh;
        logic a_ev;
        logic v_ev;
        logic ap;
        logic vp;

        cnt_next = cnt_reg;
        run_next = run_reg;
        fresh    = '0;
        a_ev     = atrial_sensed | ap_pend_reg;
        v_ev     = ventricle_sensed | vp_pend_reg;
        ap       = 1'b0;
        vp       = 1'b0;

        // Atrial event
        if (a_ev) begin
            if (run_next[dcpt_pkg::T_AEI] && !run_next[dcpt_pkg::T_PVARP]) begin
                run_next[dcpt_pkg::T_AEI] = 1'b0;
                cnt_next[dcpt_pkg::T_AEI] = '0;
            end
            if (!run_next[dcpt_pkg::T_AVI]) begin
                run_next[dcpt_pkg::T_AVI] = 1'b1;
                cnt_next[dcpt_pkg::T_AVI] = load_val[dcpt_pkg::T_AVI];
                fresh[dcpt_pkg::T_AVI]    = 1'b1;
            end
        end

        // Ventricular event, after the atrial one
        if (v_ev) begin
            if (run_next[dcpt_pkg::T_AVI] && !run_next[dcpt_pkg::T_VRP]) begin
                run_next[dcpt_pkg::T_AVI] = 1'b0;
                cnt_next[dcpt_pkg::T_AVI] = '0;
            end
            for (int t = 0; t < dcpt_pkg::NUM_TIMERS; t++) begin
                if ((t == dcpt_pkg::T_URI) || (t == dcpt_pkg::T_LRI) ||
                    (((t == dcpt_pkg::T_PVARP) || (t == dcpt_pkg::T_AEI) ||
                      (t == dcpt_pkg::T_VRP)) && !run_next[t])) begin
                    run_next[t] = 1'b1;
                    cnt_next[t] = load_val[t];
                    fresh[t]    = 1'b1;
                end
            end
        end

        // Countdown of every timer but AVI; these do not interact
        for (int t = 0; t < dcpt_pkg::NUM_TIMERS; t++) begin
            if ((t != dcpt_pkg::T_AVI) && run_next[t] && !fresh[t]) begin
                if (cnt_next[t] > COUNT_WIDTH'(1)) begin
                    cnt_next[t] = cnt_next[t] - COUNT_WIDTH'(1);
                end else begin
                    run_next[t] = 1'b0;
                    cnt_next[t] = '0;
                    if (t == dcpt_pkg::T_LRI) vp = 1'b1;
                    if (t == dcpt_pkg::T_AEI) ap = 1'b1;
                end
            end
        end

        // AVI last: sees URI after its own expiry this tick
        if (run_next[dcpt_pkg::T_AVI] && !fresh[dcpt_pkg::T_AVI]) begin
            if (cnt_next[dcpt_pkg::T_AVI] > COUNT_WIDTH'(1)) begin
                cnt_next[dcpt_pkg::T_AVI] = cnt_next[dcpt_pkg::T_AVI] - COUNT_WIDTH'(1);
            end else if (run_next[dcpt_pkg::T_URI]) begin
                cnt_next[dcpt_pkg::T_AVI] = COUNT_WIDTH'(1);
            end else begin
                run_next[dcpt_pkg::T_AVI] = 1'b0;
                cnt_next[dcpt_pkg::T_AVI] = '0;
                vp = 1'b1;
            end
        end

        ap_pend_next            = ap;
        vp_pend_next            = vp;
        res_next.atrial_pace    = ap;
        res_next.ventricle_pace = vp;
        res_next.running        = run_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < dcpt_pkg::NUM_TIMERS; t++) begin
                cnt_reg[t] <= '0;
            end
            run_reg     <= '0;
            ap_pend_reg <= 1'b0;
            vp_pend_reg <= 1'b0;
        end else if (step_en) begin
            cnt_reg     <= cnt_next;
            run_reg     <= run_next;
            ap_pend_reg <= ap_pend_next;
            vp_pend_reg <= vp_pend_next;
        end
    end

endmodule

// ===== test/dual_chamber_pacing_timer_controller_unit_test.sv =====
// Self-checking testbench for the dual-chamber pacing timer controller top level.
// Depends on dcpt_pkg and dual_chamber_pacing_timer_controller_unit; reads no files.
// Drives tick beats and interval writes, predicts every result beat and compares fields.
module dual_chamber_pacing_timer_controller_unit_test;

    localparam int unsigned     COUNT_WIDTH     = 16;
    localparam longint unsigned COUNT_MAX       = (64'd1 << COUNT_WIDTH) - 1;
    localparam int unsigned     MAX_GAP         = 17;
    // Idle margin after the last result before touching registers
    localparam int unsigned     DRAIN_CYCLES    = 4;
    localparam int unsigned     HOLD_OFF_CYCLES = 250;
    localparam int unsigned     WATCHDOG_LIMIT  = 2000;
    localparam int unsigned     RAND_PHASES     = 10;
    localparam int unsigned     TICKS_PER_PHASE = 170;

    // Indexes past the register file; writes there must be dropped
    localparam logic [dcpt_pkg::CFG_IDX_W-1:0] CFG_NONE_A = 3'd6;
    localparam logic [dcpt_pkg::CFG_IDX_W-1:0] CFG_NONE_B = 3'd7;

    // Stimulus styles of the random phases
    typedef enum logic [1:0] {
        STYLE_QUIET,    // almost no sensing: the block paces itself
        STYLE_RHYTHM,   // regular atrial then ventricular beats with dropouts
        STYLE_NOISE     // uncorrelated sensing on both chambers
    } stim_style_t;

    typedef enum logic {
        ROW_TICK,
        ROW_REG
    } row_kind_t;

    // One row of the directed plan; a pinned row carries its own expected result
    typedef struct packed {
        row_kind_t                      kind;
        logic [dcpt_pkg::CFG_IDX_W-1:0] reg_idx;
        dcpt_pkg::cfg_word_t            reg_val;
        logic                           atrial;
        logic                           ventricle;
        logic                           pinned;
        dcpt_pkg::tick_res_t            result;
    } plan_row_t;

    logic                           aclk               = 1'b0;
    logic                           aresetn            = 1'b0;
    logic                           s_valid            = 1'b0;
    logic                           s_ready;
    logic                           s_atrial_sensed    = 1'b0;
    logic                           s_ventricle_sensed = 1'b0;
    logic                           m_valid;
    logic                           m_ready            = 1'b0;
    logic                           m_atrial_pace;
    logic                           m_ventricle_pace;
    logic [5:0]                     m_running_mask;
    logic                           cfg_valid          = 1'b0;
    logic                           cfg_ready;
    logic [dcpt_pkg::CFG_IDX_W-1:0] cfg_index          = '0;
    dcpt_pkg::cfg_word_t            cfg_wdata          = '0;

    // Expected result handed from the sender to the scoreboard for pinned rows
    logic                 row_pinned = 1'b0;
    dcpt_pkg::tick_res_t  row_result = '0;

    // Pacing state as the block should hold it, indexed by timer slot
    logic [COUNT_WIDTH-1:0] timer_cnt [dcpt_pkg::NUM_TIMERS];
    dcpt_pkg::cfg_word_t    interval_len [dcpt_pkg::NUM_TIMERS];
    dcpt_pkg::tmask_t       timer_on;
    dcpt_pkg::tmask_t       fresh_slots;
    logic                   atrial_due;
    logic                   ventricle_due;
    int unsigned            expiry_seq [dcpt_pkg::NUM_TIMERS] = '{
        dcpt_pkg::T_LRI, dcpt_pkg::T_URI, dcpt_pkg::T_PVARP,
        dcpt_pkg::T_VRP, dcpt_pkg::T_AEI, dcpt_pkg::T_AVI
    };

    dcpt_pkg::tick_res_t expected_paces [$];
    plan_row_t           plan [$];
    dcpt_pkg::tick_res_t want;
    dcpt_pkg::tick_res_t predicted;
    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned results_taken = 0;
    int unsigned idle_cycles = 0;
    logic        tx_burst = 1'b0;
    logic        rx_burst = 1'b0;

    dual_chamber_pacing_timer_controller_unit #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_atrial_sensed   (s_atrial_sensed),
        .s_ventricle_sensed(s_ventricle_sensed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_atrial_pace     (m_atrial_pace),
        .m_ventricle_pace  (m_ventricle_pace),
        .m_running_mask    (m_running_mask),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------

    // Load a timer from its interval: zero counts as one, oversize clamps to full scale
    function automatic void arm_timer(input int unsigned slot);
        if (interval_len[slot] == '0)
            timer_cnt[slot] = COUNT_WIDTH'(1);
        else if (interval_len[slot] > COUNT_MAX)
            timer_cnt[slot] = COUNT_WIDTH'(COUNT_MAX);
        else
            timer_cnt[slot] = COUNT_WIDTH'(interval_len[slot]);
        timer_on[slot]    = 1'b1;
        fresh_slots[slot] = 1'b1;
    endfunction

    function automatic void halt_timer(input int unsigned slot);
        timer_cnt[slot] = '0;
        timer_on[slot]  = 1'b0;
    endfunction

    function automatic void apply_interval_write(input logic [dcpt_pkg::CFG_IDX_W-1:0] idx,
                                                 input dcpt_pkg::cfg_word_t val);
        case (idx)
            dcpt_pkg::CFG_AV_INTERVAL:       interval_len[dcpt_pkg::T_AVI]   = val;
            dcpt_pkg::CFG_ATRIAL_ESCAPE:     interval_len[dcpt_pkg::T_AEI]   = val;
            dcpt_pkg::CFG_POST_V_ATRIAL_REF: interval_len[dcpt_pkg::T_PVARP] = val;
            dcpt_pkg::CFG_V_REFRACTORY:      interval_len[dcpt_pkg::T_VRP]   = val;
            dcpt_pkg::CFG_UPPER_RATE:        interval_len[dcpt_pkg::T_URI]   = val;
            dcpt_pkg::CFG_LOWER_RATE:        interval_len[dcpt_pkg::T_LRI]   = val;
            default: ;
        endcase
    endfunction

    // Advance the pacing state by one tick and return the result beat it yields
    function automatic dcpt_pkg::tick_res_t predict_paces(input logic atrial,
                                                          input logic ventricle);
        dcpt_pkg::tick_res_t res;
        logic        a_evt;
        logic        v_evt;
        int unsigned k;
        int unsigned slot;
        // Paces emitted last tick come back as events of this tick
        a_evt       = atrial | atrial_due;
        v_evt       = ventricle | ventricle_due;
        fresh_slots = '0;
        res         = '0;
        if (a_evt) begin
            if (timer_on[dcpt_pkg::T_AEI] && !timer_on[dcpt_pkg::T_PVARP])
                halt_timer(dcpt_pkg::T_AEI);
            if (!timer_on[dcpt_pkg::T_AVI])
                arm_timer(dcpt_pkg::T_AVI);
        end
        // The ventricular event sees the atrial event's effects
        if (v_evt) begin
            if (timer_on[dcpt_pkg::T_AVI] && !timer_on[dcpt_pkg::T_VRP])
                halt_timer(dcpt_pkg::T_AVI);
            if (!timer_on[dcpt_pkg::T_PVARP])
                arm_timer(dcpt_pkg::T_PVARP);
            if (!timer_on[dcpt_pkg::T_AEI])
                arm_timer(dcpt_pkg::T_AEI);
            if (!timer_on[dcpt_pkg::T_VRP])
                arm_timer(dcpt_pkg::T_VRP);
            arm_timer(dcpt_pkg::T_URI);
            arm_timer(dcpt_pkg::T_LRI);
        end
        // Count down in expiry order; a URI expiring here no longer holds AVI back
        for (k = 0; k < dcpt_pkg::NUM_TIMERS; k++) begin
            slot = expiry_seq[k];
            if (timer_on[slot] && !fresh_slots[slot]) begin
                if (timer_cnt[slot] > 1) begin
                    timer_cnt[slot] = timer_cnt[slot] - 1'b1;
                end else if (slot == dcpt_pkg::T_AVI && timer_on[dcpt_pkg::T_URI]) begin
                    // Upper rate still running: hold AVI at one and retry next tick
                    timer_cnt[slot] = COUNT_WIDTH'(1);
                end else begin
                    halt_timer(slot);
                    // LRI and AVI together still make a single ventricular pace
                    if (slot == dcpt_pkg::T_LRI || slot == dcpt_pkg::T_AVI)
                        res.ventricle_pace = 1'b1;
                    if (slot == dcpt_pkg::T_AEI)
                        res.atrial_pace = 1'b1;
                end
            end
        end
        atrial_due    = res.atrial_pace;
        ventricle_due = res.ventricle_pace;
        res.running   = timer_on;
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Scoreboard and watchdog
    // ---------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Push the prediction before popping, so a beat in and out on one edge stays ordered
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                apply_interval_write(cfg_index, cfg_wdata);
            if (s_valid && s_ready) begin
                predicted = predict_paces(s_atrial_sensed, s_ventricle_sensed);
                expected_paces.push_back(row_pinned ? row_result : predicted);
            end
            if (m_valid && m_ready) begin
                if (expected_paces.size() == 0) begin
                    flag_mismatch("result beat with no tick waiting for it");
                end else begin
                    want = expected_paces.pop_front();
                    if (m_atrial_pace !== want.atrial_pace)
                        flag_mismatch($sformatf("result %0d atrial_pace got %b want %b",
                                                results_checked, m_atrial_pace,
                                                want.atrial_pace));
                    if (m_ventricle_pace !== want.ventricle_pace)
                        flag_mismatch($sformatf("result %0d ventricle_pace got %b want %b",
                                                results_checked, m_ventricle_pace,
                                                want.ventricle_pace));
                    if (m_running_mask !== want.running)
                        flag_mismatch($sformatf("result %0d running_mask got %b want %b",
                                                results_checked, m_running_mask,
                                                want.running));
                end
                results_checked++;
            end
            // Any beat on any channel counts as progress
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
                $display("dual_chamber_pacing_timer_controller_unit_test failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result side: random stalls, runs with no stall, and two long hold-offs
    // ---------------------------------------------------------------------

    initial begin
        int unsigned gap;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 47) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            // Hold off long enough that the block fills and stalls its input
            if (results_taken == 300 || results_taken == 1100)
                gap = HOLD_OFF_CYCLES;
            repeat (gap) @(negedge aclk) m_ready <= 1'b0;
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
        end
    end

    // ---------------------------------------------------------------------
    // Tick side
    // ---------------------------------------------------------------------

    function automatic void plan_reg(input logic [dcpt_pkg::CFG_IDX_W-1:0] idx,
                                     input dcpt_pkg::cfg_word_t val);
        plan_row_t row;
        row         = '0;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.push_back(row);
    endfunction

    function automatic void plan_tick(input logic atrial, input logic ventricle);
        plan_row_t row;
        row           = '0;
        row.kind      = ROW_TICK;
        row.atrial    = atrial;
        row.ventricle = ventricle;
        plan.push_back(row);
    endfunction

    function automatic void plan_pinned(input logic atrial, input logic ventricle,
                                        input logic ap, input logic vp,
                                        input dcpt_pkg::tmask_t mask);
        plan_row_t row;
        row                       = '0;
        row.kind                  = ROW_TICK;
        row.atrial                = atrial;
        row.ventricle             = ventricle;
        row.pinned                = 1'b1;
        row.result.atrial_pace    = ap;
        row.result.ventricle_pace = vp;
        row.result.running        = mask;
        plan.push_back(row);
    endfunction

    function automatic dcpt_pkg::cfg_word_t pick_interval();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return dcpt_pkg::cfg_word_t'($urandom);
            default: return dcpt_pkg::cfg_word_t'($urandom_range(1, 30));
        endcase
    endfunction

    // Offer one tick beat after a random gap; hold it until the block takes it
    task automatic send_tick(input logic atrial, input logic ventricle,
                             input logic pinned, input dcpt_pkg::tick_res_t result);
        int unsigned gap;
        if ($urandom_range(0, 47) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) @(negedge aclk) s_valid <= 1'b0;
        @(negedge aclk);
        s_valid            <= 1'b1;
        s_atrial_sensed    <= atrial;
        s_ventricle_sensed <= ventricle;
        row_pinned         <= pinned;
        row_result         <= result;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Write one interval register once every result is in and the pipeline is empty
    task automatic write_reg(input logic [dcpt_pkg::CFG_IDX_W-1:0] idx,
                             input dcpt_pkg::cfg_word_t val);
        @(negedge aclk) s_valid <= 1'b0;
        while (expected_paces.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned phase;
        int unsigned n;
        int unsigned idx;
        int unsigned period;
        int unsigned av_gap;
        stim_style_t style;
        logic        atrial;
        logic        ventricle;

        // Reset state of the prediction
        interval_len[dcpt_pkg::T_LRI]   = dcpt_pkg::RST_LRI;
        interval_len[dcpt_pkg::T_URI]   = dcpt_pkg::RST_URI;
        interval_len[dcpt_pkg::T_AVI]   = dcpt_pkg::RST_AVI;
        interval_len[dcpt_pkg::T_AEI]   = dcpt_pkg::RST_AEI;
        interval_len[dcpt_pkg::T_PVARP] = dcpt_pkg::RST_PVARP;
        interval_len[dcpt_pkg::T_VRP]   = dcpt_pkg::RST_VRP;
        for (idx = 0; idx < dcpt_pkg::NUM_TIMERS; idx++)
            timer_cnt[idx] = '0;
        timer_on      = '0;
        fresh_slots   = '0;
        atrial_due    = 1'b0;
        ventricle_due = 1'b0;

        // Directed plan. Zero intervals load as one, so every timer expires on the
        // tick after it starts; writes to unused indexes must change nothing.
        for (idx = dcpt_pkg::CFG_AV_INTERVAL; idx <= dcpt_pkg::CFG_LOWER_RATE; idx++)
            plan_reg(idx[dcpt_pkg::CFG_IDX_W-1:0], '0);
        plan_reg(CFG_NONE_A, 16'hFFFF);
        plan_reg(CFG_NONE_B, 16'h5A5A);
        plan_pinned(1'b0, 1'b0, 1'b0, 1'b0, 6'h00);
        plan_pinned(1'b0, 1'b1, 1'b0, 1'b0, 6'h3B);
        plan_pinned(1'b0, 1'b0, 1'b1, 1'b1, 6'h00);
        // Both paces return as events: AVI starts and is stopped by the ventricular one
        plan_pinned(1'b0, 1'b0, 1'b0, 1'b0, 6'h3B);
        plan_tick(1'b1, 1'b0);
        plan_tick(1'b0, 1'b0);
        plan_tick(1'b1, 1'b1);
        plan_tick(1'b0, 1'b0);
        // Short AVI under a longer upper rate: AVI is held, then LRI and AVI may meet
        plan_reg(dcpt_pkg::CFG_AV_INTERVAL, 16'd1);
        plan_reg(dcpt_pkg::CFG_ATRIAL_ESCAPE, 16'd6);
        plan_reg(dcpt_pkg::CFG_POST_V_ATRIAL_REF, 16'd1);
        plan_reg(dcpt_pkg::CFG_V_REFRACTORY, 16'd1);
        plan_reg(dcpt_pkg::CFG_UPPER_RATE, 16'd3);
        plan_reg(dcpt_pkg::CFG_LOWER_RATE, 16'd4);
        plan_tick(1'b0, 1'b1);
        plan_tick(1'b1, 1'b0);
        plan_tick(1'b0, 1'b0);
        plan_tick(1'b0, 1'b0);
        plan_tick(1'b0, 1'b0);
        plan_tick(1'b0, 1'b0);
        plan_tick(1'b1, 1'b0);
        plan_tick(1'b0, 1'b0);
        // Full-scale intervals
        for (idx = dcpt_pkg::CFG_AV_INTERVAL; idx <= dcpt_pkg::CFG_LOWER_RATE; idx++)
            plan_reg(idx[dcpt_pkg::CFG_IDX_W-1:0], 16'hFFFF);
        plan_tick(1'b1, 1'b1);
        plan_tick(1'b0, 1'b0);
        plan_tick(1'b1, 1'b0);
        plan_tick(1'b0, 1'b1);
        plan_tick(1'b0, 1'b0);

        // Hold reset from the start, then release it once
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_tick(plan[i].atrial, plan[i].ventricle, plan[i].pinned,
                          plan[i].result);
        end

        // Random phases: fresh intervals each phase, then a stretch of ticks
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            for (idx = dcpt_pkg::CFG_AV_INTERVAL; idx <= dcpt_pkg::CFG_LOWER_RATE; idx++)
                write_reg(idx[dcpt_pkg::CFG_IDX_W-1:0], pick_interval());
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? CFG_NONE_A : CFG_NONE_B,
                          dcpt_pkg::cfg_word_t'($urandom));
            style  = stim_style_t'($urandom_range(STYLE_QUIET, STYLE_NOISE));
            period = $urandom_range(4, 40);
            av_gap = $urandom_range(1, period - 1);
            for (n = 0; n < TICKS_PER_PHASE; n++) begin
                case (style)
                    STYLE_QUIET: begin
                        atrial    = ($urandom_range(0, 49) == 0);
                        ventricle = ($urandom_range(0, 49) == 0);
                    end
                    STYLE_RHYTHM: begin
                        // Drop some beats so the escape and AV timers get to pace
                        atrial    = ((n % period) == 0) && ($urandom_range(0, 9) != 0);
                        ventricle = ((n % period) == av_gap) && ($urandom_range(0, 6) != 0);
                        atrial    = atrial ^ ($urandom_range(0, 31) == 0);
                        ventricle = ventricle ^ ($urandom_range(0, 31) == 0);
                    end
                    default: begin
                        atrial    = ($urandom_range(0, 2) == 0);
                        ventricle = ($urandom_range(0, 2) == 0);
                    end
                endcase
                send_tick(atrial, ventricle, 1'b0, '0);
            end
        end

        // Drain: drop valid, wait for every result, then let the pipeline settle
        @(negedge aclk) s_valid <= 1'b0;
        while (expected_paces.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("dual_chamber_pacing_timer_controller_unit_test passed");
        else
            $display("dual_chamber_pacing_timer_controller_unit_test failed");
        $finish;
    end

endmodule
